@@ src/ahp_pkg.sv @@
// ----------------------------------------------------------------------------
// ahp_pkg
// Shared types and constants of the axis homing and positioning unit.
// ----------------------------------------------------------------------------
package ahp_pkg;

	// Width of the internal position arithmetic (16 to 32)
	localparam int POSITION_BITS = 24;
	// Width of the drive duty path (8 to 16)
	localparam int DRIVE_BITS    = 12;

	// Fixed field widths of the stream items
	localparam int KIND_W   = 2;
	localparam int CMD_W    = 16;
	localparam int ENC_W    = 24;
	localparam int LEVEL_W  = 12;
	localparam int PPM_W    = 10;
	localparam int BOTTOM_W = 10;
	localparam int TOL_W    = 16;
	localparam int STATUS_W = 4;
	localparam int POS_OUT_W = 24;
	localparam int PROD_W   = PPM_W + BOTTOM_W;
	localparam int DELAY_W  = 8;

	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 64;
	localparam int APB_ADDR_W = 5;
	localparam int APB_DATA_W = 32;

	// Drive duty mask: DRIVE_BITS wide, then clipped to the output field
	localparam logic [LEVEL_W-1:0] DRIVE_MASK = LEVEL_W'((64'd1 << DRIVE_BITS) - 64'd1);

	// Largest positive position
	localparam logic [31:0] POS_MAX = 32'((64'd1 << (POSITION_BITS - 1)) - 64'd1);

	// Sequence delays in ticks
	localparam logic [DELAY_W-1:0] SETTLE_TICKS     = DELAY_W'(10);
	localparam logic [DELAY_W-1:0] DOWN_PAUSE_TICKS = DELAY_W'(50);
	localparam logic [DELAY_W-1:0] UP_PAUSE_TICKS   = DELAY_W'(200);
	localparam logic [DELAY_W-1:0] STOP_TICKS       = DELAY_W'(1);

	// Register reset values
	localparam logic [LEVEL_W-1:0]  HOME_LEVEL_RST = LEVEL_W'(300);
	localparam logic [LEVEL_W-1:0]  MOVE_LEVEL_RST = LEVEL_W'(400);
	localparam logic [PPM_W-1:0]    PPM_RST        = PPM_W'(377);
	localparam logic [BOTTOM_W-1:0] BOTTOM_RST     = BOTTOM_W'(300);
	localparam logic [TOL_W-1:0]    TOL_RST        = TOL_W'(100);

	// Register indexes (byte address / 4)
	localparam logic [2:0] REG_HOME_LEVEL = 3'd0;
	localparam logic [2:0] REG_MOVE_LEVEL = 3'd1;
	localparam logic [2:0] REG_PPM        = 3'd2;
	localparam logic [2:0] REG_BOTTOM     = 3'd3;
	localparam logic [2:0] REG_TOLERANCE  = 3'd4;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_HOME  = 2'd1,
		KIND_MOVE  = 2'd2,
		KIND_SERVO = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE          = 4'd0,
		ST_HOMING_DOWN   = 4'd1,
		ST_DOWN_HOMING_UP = 4'd2,
		ST_HOMING_UP     = 4'd3,
		ST_HOMED         = 4'd4,
		ST_NOT_HOMED     = 4'd5,
		ST_ABOVE_TOP     = 4'd6,
		ST_BELOW_BOTTOM  = 4'd7,
		ST_CLOSE_ENOUGH  = 4'd8,
		ST_MOVING        = 4'd9,
		ST_ARRIVED       = 4'd10,
		ST_SERVO_SET     = 4'd11,
		ST_BUSY          = 4'd12
	} status_t;

	// Outcome of a move request check
	typedef struct packed {
		status_t                   status;
		logic                      start;
		logic                      down;
		logic [POSITION_BITS-1:0]  target;
	} move_dec_t;

endpackage

@@ src/ahp_move_check.sv @@
// ----------------------------------------------------------------------------
// ahp_move_check
// Validates a move request and converts the millimetre target to pulses.
// ----------------------------------------------------------------------------
module ahp_move_check (
	input  logic signed [ahp_pkg::CMD_W-1:0]          cmd,
	input  logic signed [ahp_pkg::POSITION_BITS-1:0]  pos,
	input  logic                                      homed,
	input  logic [ahp_pkg::PPM_W-1:0]                 pulses_per_mm,
	input  logic [ahp_pkg::BOTTOM_W-1:0]              bottom_limit_mm,
	input  logic [ahp_pkg::TOL_W-1:0]                 arrive_tolerance,
	output ahp_pkg::move_dec_t                        dec
);
	import ahp_pkg::*;

	localparam int PW = POSITION_BITS;

	logic [PROD_W-1:0]   prod;
	logic [31:0]         prod_ext;
	logic [31:0]         tgt_sat;
	logic signed [PW-1:0] tgt;
	logic signed [PW:0]   diff;
	logic [PW:0]          distance;

	// Target is within 0..1023 whenever it is used, so ten bits suffice
	assign prod     = PPM_W'(cmd[BOTTOM_W-1:0]) * pulses_per_mm;
	assign prod_ext = 32'(prod);
	assign tgt_sat  = (prod_ext > POS_MAX) ? POS_MAX : prod_ext;
	assign tgt      = PW'(tgt_sat);
	assign diff     = (PW+1)'(tgt) - (PW+1)'(pos);
	assign distance = diff[PW] ? (PW+1)'(-diff) : (PW+1)'(diff);

	always_comb begin
		dec.status = ST_MOVING;
		dec.start  = 1'b0;
		dec.down   = tgt > pos;
		dec.target = tgt;
		if (!homed) begin
			dec.status = ST_NOT_HOMED;
		end else if (cmd < 0) begin
			dec.status = ST_ABOVE_TOP;
		end else if (cmd > $signed({1'b0, CMD_W'(bottom_limit_mm)})) begin
			dec.status = ST_BELOW_BOTTOM;
		end else if (distance < (PW+1)'(arrive_tolerance)) begin
			dec.status = ST_CLOSE_ENOUGH;
		end else begin
			dec.start = 1'b1;
		end
	end

endmodule

@@ src/axis_homing_and_positioning_unit.sv @@
// ----------------------------------------------------------------------------
// axis_homing_and_positioning_unit
// Millisecond-tick homing and move-to-target controller for one motor axis.
// ----------------------------------------------------------------------------
// Every request on the slave stream (a tick, or a home, move or servo
// command) yields exactly one result on the master stream, in order. A
// request sits in an input register while the sequencer works out its
// effect, and the result is held in an output register. A new request
// is taken every clock as long as the master side keeps up. A stalled
// result does not
// block the input register from filling. Homing backs off a closed top limit
// switch, settles 10 ticks, pauses 50 ticks, drives up to the switch, settles
// 10 ticks, pauses 200 ticks and then takes the present encoder count as
// zero. A move drives toward the target in pulses and stops on the tick
// after the target is reached or passed. Home, move and servo commands that
// arrive during a sequence are dropped with a busy status. Registers are
// written through the APB port and must only be changed while idle.
// ----------------------------------------------------------------------------
module axis_homing_and_positioning_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// Slave stream
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [15:0] command_value, [16] limit_closed, [40:17] encoder_count, rest zero
	input  logic [ahp_pkg::IN_DATA_W-1:0]       s_axis_tdata,
	// [1:0] kind
	input  logic [ahp_pkg::KIND_W-1:0]          s_axis_tuser,
	// Master stream
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [0] drive_down, [12:1] drive_level, [13] servo_enabled,
	// [29:14] servo_setting, [33:30] status_code, [34] homed, [35] busy_res,
	// [59:36] axis_position, [63:60] zero
	output logic [ahp_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// APB configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [ahp_pkg::APB_ADDR_W-1:0]      paddr,
	input  logic [ahp_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [ahp_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);
	import ahp_pkg::*;

	localparam int PW = POSITION_BITS;

	typedef enum logic [3:0] {
		PH_IDLE, PH_HOME_DOWN, PH_DOWN_SETTLE, PH_DOWN_PAUSE, PH_HOME_UP,
		PH_UP_SETTLE, PH_UP_PAUSE, PH_MOVE_DOWN, PH_MOVE_UP, PH_MOVE_STOP
	} phase_t;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	logic [LEVEL_W-1:0]  home_level_q;
	logic [LEVEL_W-1:0]  move_level_q;
	logic [PPM_W-1:0]    ppm_q;
	logic [BOTTOM_W-1:0] bottom_q;
	logic [TOL_W-1:0]    tol_q;
	logic                cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			home_level_q <= HOME_LEVEL_RST;
			move_level_q <= MOVE_LEVEL_RST;
			ppm_q        <= PPM_RST;
			bottom_q     <= BOTTOM_RST;
			tol_q        <= TOL_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_HOME_LEVEL: home_level_q <= pwdata[LEVEL_W-1:0];
				REG_MOVE_LEVEL: move_level_q <= pwdata[LEVEL_W-1:0];
				REG_PPM:        ppm_q        <= pwdata[PPM_W-1:0];
				REG_BOTTOM:     bottom_q     <= pwdata[BOTTOM_W-1:0];
				REG_TOLERANCE:  tol_q        <= pwdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_HOME_LEVEL: prdata = APB_DATA_W'(home_level_q);
			REG_MOVE_LEVEL: prdata = APB_DATA_W'(move_level_q);
			REG_PPM:        prdata = APB_DATA_W'(ppm_q);
			REG_BOTTOM:     prdata = APB_DATA_W'(bottom_q);
			REG_TOLERANCE:  prdata = APB_DATA_W'(tol_q);
			default:        prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------
	// Input register and flow control
	// ------------------------------------------------------------------
	logic                     valid_s1;
	kind_t                    kind_s1;
	logic signed [CMD_W-1:0]  cmd_s1;
	logic                     closed_s1;
	logic signed [ENC_W-1:0]  raw_s1;
	logic                     advance;
	logic                     in_take;

	// Advance the held request whenever the result register is free or draining
	assign advance       = valid_s1 && (!m_axis_tvalid || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1   <= kind_t'(s_axis_tuser);
			cmd_s1    <= s_axis_tdata[CMD_W-1:0];
			closed_s1 <= s_axis_tdata[CMD_W];
			raw_s1    <= s_axis_tdata[CMD_W+ENC_W:CMD_W+1];
		end
	end

	// ------------------------------------------------------------------
	// Sequencer state
	// ------------------------------------------------------------------
	phase_t                   phase_q, phase_d;
	logic [DELAY_W-1:0]       delay_q, delay_d;
	logic                     homed_q, homed_d;
	logic [PW-1:0]            zero_q, zero_d;
	logic signed [PW-1:0]     target_q, target_d;
	logic                     down_q, down_d;
	logic [LEVEL_W-1:0]       level_q, level_d;
	logic                     servo_on_q, servo_on_d;
	logic [CMD_W-1:0]         servo_pos_q, servo_pos_d;
	status_t                  status_d;

	logic [PW-1:0]            raw_ext;
	logic signed [PW-1:0]     pos;
	logic signed [PW-1:0]     pos_out;
	logic [DELAY_W-1:0]       delay_dec;
	move_dec_t                mv;

	// Position is zero point minus raw count, so it grows going down
	assign raw_ext   = PW'(raw_s1);
	assign pos       = $signed(zero_q - raw_ext);
	assign pos_out   = $signed(zero_d - raw_ext);
	assign delay_dec = delay_q - DELAY_W'(1);

	ahp_move_check u_move_check (
		.cmd              (cmd_s1),
		.pos              (pos),
		.homed            (homed_q),
		.pulses_per_mm    (ppm_q),
		.bottom_limit_mm  (bottom_q),
		.arrive_tolerance (tol_q),
		.dec              (mv)
	);

	always_comb begin
		phase_d     = phase_q;
		delay_d     = delay_q;
		homed_d     = homed_q;
		zero_d      = zero_q;
		target_d    = target_q;
		down_d      = down_q;
		level_d     = level_q;
		servo_on_d  = servo_on_q;
		servo_pos_d = servo_pos_q;
		status_d    = ST_NONE;

		if (kind_s1 != KIND_TICK && phase_q != PH_IDLE) begin
			// Drop commands during a sequence
			status_d = ST_BUSY;
		end else begin
			case (kind_s1)
				KIND_HOME: begin
					level_d = home_level_q & DRIVE_MASK;
					if (closed_s1) begin
						down_d   = 1'b1;
						phase_d  = PH_HOME_DOWN;
						status_d = ST_HOMING_DOWN;
					end else begin
						down_d   = 1'b0;
						phase_d  = PH_HOME_UP;
						status_d = ST_DOWN_HOMING_UP;
					end
				end
				KIND_MOVE: begin
					status_d = mv.status;
					if (mv.start) begin
						target_d = mv.target;
						down_d   = mv.down;
						level_d  = move_level_q & DRIVE_MASK;
						phase_d  = mv.down ? PH_MOVE_DOWN : PH_MOVE_UP;
					end
				end
				KIND_SERVO: begin
					servo_on_d  = 1'b1;
					servo_pos_d = cmd_s1;
					status_d    = ST_SERVO_SET;
				end
				default: begin
					// Tick: advance the running sequence
					case (phase_q)
						PH_IDLE: ;
						PH_HOME_DOWN: begin
							if (!closed_s1) begin
								phase_d = PH_DOWN_SETTLE;
								delay_d = SETTLE_TICKS;
							end
						end
						PH_DOWN_SETTLE: begin
							delay_d = delay_dec;
							if (delay_dec == '0) begin
								level_d = '0;
								phase_d = PH_DOWN_PAUSE;
								delay_d = DOWN_PAUSE_TICKS;
							end
						end
						PH_DOWN_PAUSE: begin
							delay_d = delay_dec;
							if (delay_dec == '0) begin
								down_d   = 1'b0;
								level_d  = home_level_q & DRIVE_MASK;
								phase_d  = PH_HOME_UP;
								status_d = ST_HOMING_UP;
							end
						end
						PH_HOME_UP: begin
							if (closed_s1) begin
								phase_d = PH_UP_SETTLE;
								delay_d = SETTLE_TICKS;
							end
						end
						PH_UP_SETTLE: begin
							delay_d = delay_dec;
							if (delay_dec == '0) begin
								level_d = '0;
								phase_d = PH_UP_PAUSE;
								delay_d = UP_PAUSE_TICKS;
							end
						end
						PH_UP_PAUSE: begin
							delay_d = delay_dec;
							if (delay_dec == '0) begin
								zero_d   = raw_ext;
								homed_d  = 1'b1;
								phase_d  = PH_IDLE;
								status_d = ST_HOMED;
							end
						end
						PH_MOVE_DOWN: begin
							if (pos >= target_q) begin
								phase_d = PH_MOVE_STOP;
								delay_d = STOP_TICKS;
							end
						end
						PH_MOVE_UP: begin
							if (pos <= target_q) begin
								phase_d = PH_MOVE_STOP;
								delay_d = STOP_TICKS;
							end
						end
						PH_MOVE_STOP: begin
							delay_d = delay_dec;
							if (delay_dec == '0) begin
								level_d  = '0;
								phase_d  = PH_IDLE;
								status_d = ST_ARRIVED;
							end
						end
						default: phase_d = PH_IDLE;
					endcase
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// State and result register
	// ------------------------------------------------------------------
	logic [OUT_DATA_W-1:0] result_d;

	assign result_d = {
		4'b0000,
		POS_OUT_W'(pos_out),
		phase_d != PH_IDLE,
		homed_d,
		status_d,
		servo_pos_d,
		servo_on_d,
		level_d,
		down_d
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			delay_q       <= '0;
			homed_q       <= 1'b0;
			zero_q        <= '0;
			target_q      <= '0;
			down_q        <= 1'b0;
			level_q       <= '0;
			servo_on_q    <= 1'b0;
			servo_pos_q   <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
		end else begin
			if (advance) begin
				phase_q      <= phase_d;
				delay_q      <= delay_d;
				homed_q      <= homed_d;
				zero_q       <= zero_d;
				target_q     <= target_d;
				down_q       <= down_d;
				level_q      <= level_d;
				servo_on_q   <= servo_on_d;
				servo_pos_q  <= servo_pos_d;
				m_axis_tdata <= result_d;
			end
			if (advance) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
		end
	end

endmodule

@@ src/ahp_checker.sv @@
// ----------------------------------------------------------------------------
// ahp_checker
// Port-level checks of the axis homing and positioning unit.
// ----------------------------------------------------------------------------
module ahp_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [ahp_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
	import ahp_pkg::*;

	logic [LEVEL_W-1:0]   level;
	logic [STATUS_W-1:0]  status;
	logic                 homed;
	logic                 busy;
	logic [POS_OUT_W-1:0] position;

	assign level    = m_axis_tdata[12:1];
	assign status   = m_axis_tdata[33:30];
	assign homed    = m_axis_tdata[34];
	assign busy     = m_axis_tdata[35];
	assign position = m_axis_tdata[59:36];

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Motor stopped whenever no sequence runs
	a_idle_stop: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !busy |-> level == '0)
		else $error("drive on while idle");

	// Homing end sets the flag and the zero point
	a_homed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == ST_HOMED |-> homed && !busy && position == '0)
		else $error("homed result inconsistent");

	// Busy rejection only during a sequence
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == ST_BUSY |-> busy)
		else $error("busy status while idle");

	// A move refused for lack of homing leaves the flag clear
	a_not_homed: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == ST_NOT_HOMED |-> !homed && !busy)
		else $error("not-homed status inconsistent");

endmodule

bind axis_homing_and_positioning_unit ahp_checker u_ahp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
